// ----- rtl/core/wav_header_parser_top_assert.svh -----
// assertion macros for the wav header parser
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef WAV_HEADER_PARSER_TOP_ASSERT_SVH
`define WAV_HEADER_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define WHP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("whp assertion failed");

`define WHP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("whp implication failed");

`define WHP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("whp next-cycle check failed");

`else

`define WHP_ASSERT(label, clk, rst, prop)
`define WHP_ASSERT_IMP(label, clk, rst, ante, cons)
`define WHP_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/whp_pkg.sv -----
// types and constants shared by the wav header parser
// no dependencies
`default_nettype none

package whp_pkg;

   localparam int RATE_W        = 20;
   localparam int MAX_DOUBLINGS = 7;
   localparam int SHIFT_W       = 32 + MAX_DOUBLINGS;

   localparam logic [31:0]       ID_RIFF      = 32'h46464952;
   localparam logic [31:0]       ID_WAVE      = 32'h45564157;
   localparam logic [31:0]       ID_DATA      = 32'h61746164;
   localparam logic [31:0]       ID_FMT       = 32'h20746d66;
   localparam logic [31:0]       FMT_BODY_LEN = 32'd16;
   localparam logic [RATE_W-1:0] RESET_RATE   = 20'd44100;

   typedef enum logic [3:0] {
      PH_RIFF_ID,
      PH_RIFF_SIZE,
      PH_WAVE_ID,
      PH_FMT_ID,
      PH_FMT_SIZE,
      PH_FMT_BODY,
      PH_FMT_SKIP,
      PH_CK_ID,
      PH_CK_OTHER,
      PH_CK_DATA,
      PH_CK_SKIP
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_NOT_WAVE,
      ST_NO_FMT,
      ST_NO_DATA,
      ST_BAD_RATE
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] data_length;
      logic [7:0]  skip_factor;
      logic [1:0]  sample_bytes;
      logic [15:0] channel_count;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/core/whp_parser.sv -----
// byte-wise riff/wave header parse state and result formation
// depends on whp_pkg
`default_nettype none

module whp_parser
   import whp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              start_of_file,
   input  wire logic              end_of_file,
   input  wire logic [RATE_W-1:0] target_rate,
   output logic                   res_valid,
   output result_type             res
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic        finished_ff, finished_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] skip_ff, skip_in;
   logic [15:0] channels_ff, channels_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic        rate_ok_ff, rate_ok_in;
   logic [7:0]  rate_skip_ff, rate_skip_in;

   // rate check runs continuously on the stored rate, long before the data size is in
   always_comb begin
      rate_ok_in   = 1'b0;
      rate_skip_in = '0;
      for (int d = 0; d <= MAX_DOUBLINGS; d++) begin
         if ((rate_ff != '0) &&
             ((SHIFT_W'(rate_ff) << d) == SHIFT_W'(target_rate))) begin
            rate_ok_in   = 1'b1;
            rate_skip_in = 8'(1 << d);
         end
      end
   end

   always_comb begin
      phase_type   ph;
      logic [3:0]  pos;
      logic        fin;
      logic [31:0] word_new;
      logic        done;
      logic [31:0] skip_next;
      logic        hit;

      ph        = start_of_file ? PH_RIFF_ID : phase_ff;
      pos       = start_of_file ? 4'd0 : pos_ff;
      fin       = start_of_file ? 1'b0 : finished_ff;
      word_new  = {data_byte, word_ff[31:8]};
      done      = (pos == 4'd3);
      skip_next = (skip_ff != '0) ? skip_ff - 32'd1 : '0;
      hit       = 1'b0;

      phase_in    = phase_ff;
      pos_in      = pos_ff;
      finished_in = finished_ff;
      word_in     = word_ff;
      skip_in     = skip_ff;
      channels_in = channels_ff;
      rate_in     = rate_ff;
      bits_in     = bits_ff;

      res               = '0;
      res.status        = ST_NOT_WAVE;
      res.sample_bytes  = 2'd1;

      if (accept) begin
         phase_in    = ph;
         pos_in      = pos;
         finished_in = fin;
         if (!fin) begin
            case (ph)
               PH_RIFF_ID, PH_RIFF_SIZE, PH_WAVE_ID, PH_FMT_ID, PH_FMT_SIZE,
               PH_CK_ID, PH_CK_OTHER, PH_CK_DATA: begin
                  word_in = word_new;
                  pos_in  = done ? 4'd0 : pos + 4'd1;
                  if (done) begin
                     case (ph)
                        PH_RIFF_ID: begin
                           if (word_new != ID_RIFF) begin
                              hit        = 1'b1;
                              res.status = ST_NOT_WAVE;
                           end else begin
                              phase_in = PH_RIFF_SIZE;
                           end
                        end
                        PH_RIFF_SIZE: phase_in = PH_WAVE_ID;
                        PH_WAVE_ID: begin
                           if (word_new != ID_WAVE) begin
                              hit        = 1'b1;
                              res.status = ST_NOT_WAVE;
                           end else begin
                              phase_in = PH_FMT_ID;
                           end
                        end
                        PH_FMT_ID: begin
                           if (word_new != ID_FMT) begin
                              hit        = 1'b1;
                              res.status = ST_NO_FMT;
                           end else begin
                              phase_in = PH_FMT_SIZE;
                           end
                        end
                        PH_FMT_SIZE: begin
                           skip_in  = (word_new > FMT_BODY_LEN) ? word_new - FMT_BODY_LEN : '0;
                           phase_in = PH_FMT_BODY;
                        end
                        PH_CK_ID: phase_in = (word_new == ID_DATA) ? PH_CK_DATA : PH_CK_OTHER;
                        PH_CK_OTHER: begin
                           skip_in  = word_new;
                           phase_in = (word_new != '0) ? PH_CK_SKIP : PH_CK_ID;
                        end
                        PH_CK_DATA: begin
                           hit = 1'b1;
                           if (rate_ok_ff) begin
                              res.status        = ST_OK;
                              res.data_length   = word_new;
                              res.skip_factor   = rate_skip_ff;
                              res.sample_bytes  = (bits_ff == 16'd16) ? 2'd2 : 2'd1;
                              res.channel_count = channels_ff;
                           end else begin
                              res.status = ST_BAD_RATE;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
               PH_FMT_BODY: begin
                  case (pos)
                     4'd2:  channels_in[7:0]  = data_byte;
                     4'd3:  channels_in[15:8] = data_byte;
                     4'd4:  rate_in[7:0]      = data_byte;
                     4'd5:  rate_in[15:8]     = data_byte;
                     4'd6:  rate_in[23:16]    = data_byte;
                     4'd7:  rate_in[31:24]    = data_byte;
                     4'd14: bits_in[7:0]      = data_byte;
                     4'd15: bits_in[15:8]     = data_byte;
                     default: ;
                  endcase
                  pos_in = pos + 4'd1;
                  if (pos == 4'd15) begin
                     phase_in = (skip_ff != '0) ? PH_FMT_SKIP : PH_CK_ID;
                  end
               end
               PH_FMT_SKIP, PH_CK_SKIP: begin
                  skip_in = skip_next;
                  if (skip_next == '0) begin
                     phase_in = PH_CK_ID;
                  end
               end
               default: ;
            endcase

            // end of file without a completed result reports what is missing
            if (!hit && end_of_file) begin
               hit = 1'b1;
               if (phase_in <= PH_WAVE_ID) begin
                  res.status = ST_NOT_WAVE;
               end else if (phase_in <= PH_FMT_SIZE) begin
                  res.status = ST_NO_FMT;
               end else begin
                  res.status = ST_NO_DATA;
               end
            end
            if (hit) begin
               finished_in = 1'b1;
            end
         end
      end
      res_valid = hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_RIFF_ID;
         pos_ff      <= '0;
         finished_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      skip_ff      <= skip_in;
      channels_ff  <= channels_in;
      rate_ff      <= rate_in;
      bits_ff      <= bits_in;
      rate_ok_ff   <= rate_ok_in;
      rate_skip_ff <= rate_skip_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/wav_header_parser_top.sv -----
// wav header parser top level: target rate register, parser and output skid stage
// depends on whp_pkg, whp_parser and wav_header_parser_top_assert.svh
`default_nettype none
`include "wav_header_parser_top_assert.svh"

// Accepts one file byte per cycle while req_tready is high and emits a single result per
// file into the output register (or the skid register if the output is stalled) after the
// byte that completes it (last byte of the data chunk size, bad identifier, or end of file).
// Each byte is a single state update, so the sustained rate is one transaction per clock
// while req_tready is high; it drops only while the skid register holds an untaken result.
// The sample-rate check compares each power-of-two multiple of the stored rate against
// the target in parallel and is registered while the remaining header bytes stream by.
// csr_wdata sets the target rate and should only be written between files.
module wav_header_parser_top
   import whp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [RATE_W-1:0] csr_wdata,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // data_byte
   input  wire logic              req_tuser,   // start_of_file
   input  wire logic              req_tlast,   // end_of_file
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // data_length[31:0], skip_factor[39:32], sample_bytes[41:40],
   // channel_count[57:42], zero fill[63:58]
   output logic [63:0]            rsp_tdata,
   output logic [2:0]             rsp_tuser    // status
);

   logic [RATE_W-1:0] target_ff, target_in;
   logic              accept;
   logic              res_valid;
   result_type        res;
   result_type        out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   result_type        skid_ff, skid_in;
   logic              skid_valid_ff, skid_valid_in;
   logic              out_stalled;

   assign target_in   = csr_we ? csr_wdata : target_ff;
   assign req_tready  = !skid_valid_ff;
   assign accept      = req_tvalid && req_tready;
   assign out_stalled = out_valid_ff && !rsp_tready;

   // the rate check sees a new target in the cycle it is written
   whp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .start_of_file (req_tuser),
      .end_of_file   (req_tlast),
      .target_rate   (target_in),
      .res_valid     (res_valid),
      .res           (res)
   );

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_stalled) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_valid;
         end
      end else if (res_valid) begin
         // output stalled: park the new result behind it
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= RESET_RATE;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         target_ff     <= target_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {6'd0, out_ff.channel_count, out_ff.sample_bytes,
                        out_ff.skip_factor, out_ff.data_length};

   `WHP_ASSERT(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff)
   `WHP_ASSERT_NXT(a_stall_fills_skid, clock, reset, res_valid && out_stalled, skid_valid_ff)
   `WHP_ASSERT_NXT(a_skid_drains, clock, reset, skid_valid_ff && rsp_tready, !skid_valid_ff)

endmodule

`default_nettype wire
